### hw/rtl/dnpm_pkg.sv
// Package for the dithered nearest-palette mapper: microcode step and condition
// codes, control word and status types, the microprogram table and constants.
// No dependencies.
package dnpm_pkg;

  localparam logic       CMD_LOAD       = 1'b0;
  localparam logic       CMD_PIXEL      = 1'b1;
  localparam logic [7:0] CELL_MASK      = 8'd248;
  localparam logic [7:0] CELL_HALF      = 8'd4;
  localparam int         DIST_W         = 18;
  localparam int         SQ_W           = 16;
  localparam logic [8:0] PSIZE_RESET    = 9'd256;
  localparam logic       REG_PALETTE_SIZE = 1'b0;

  typedef enum logic [2:0] {
    S_FETCH,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } step_e;

  typedef enum logic [2:0] {
    C_NO_ITEM,
    C_IS_LOAD,
    C_SCAN_MORE,
    C_PIPE_BUSY,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    logic  prep;
    logic  load;
    logic  scan;
    logic  emit;
    cond_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } ctl_t;

  typedef struct packed {
    logic item_valid;
    logic is_load;
    logic scan_more;
    logic pipe_busy;
    logic out_busy;
  } stat_t;

  function automatic ctl_t ucode(step_e step);
    ctl_t w;
    w = '{in_ready: 1'b0, prep: 1'b0, load: 1'b0, scan: 1'b0, emit: 1'b0,
          cond: C_NO_ITEM, tgt_t: S_FETCH, tgt_f: S_FETCH};
    unique case (step)
      S_FETCH: begin
        w.in_ready = 1'b1;
        w.cond     = C_NO_ITEM;
        w.tgt_t    = S_FETCH;
        w.tgt_f    = S_DECODE;
      end
      S_DECODE: begin
        w.prep  = 1'b1;
        w.load  = 1'b1;
        w.cond  = C_IS_LOAD;
        w.tgt_t = S_FETCH;
        w.tgt_f = S_SCAN;
      end
      S_SCAN: begin
        w.scan  = 1'b1;
        w.cond  = C_SCAN_MORE;
        w.tgt_t = S_SCAN;
        w.tgt_f = S_DRAIN;
      end
      S_DRAIN: begin
        w.cond  = C_PIPE_BUSY;
        w.tgt_t = S_DRAIN;
        w.tgt_f = S_EMIT;
      end
      S_EMIT: begin
        w.emit  = 1'b1;
        w.cond  = C_OUT_BUSY;
        w.tgt_t = S_EMIT;
        w.tgt_f = S_FETCH;
      end
      default: begin
        w.cond  = C_NO_ITEM;
        w.tgt_t = S_FETCH;
        w.tgt_f = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/dithered_nearest_palette_mapper_unit.sv
// Top level of the dithered nearest-palette mapper: APB register, sequencer
// and datapath. Depends on dnpm_pkg, dnpm_seq, dnpm_datapath.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | cmd_i entry_index_i red_i green_i blue_i
//           |                         | first_of_row_i
//   out     | out_valid_o/out_ready_i | color_index_o
//   cfg     | psel penable pwrite     | paddr pwdata prdata (palette_size at 0)
//
// A pixel scans N palette entries, N being palette_size clamped to
// 1..PALETTE_DEPTH: one palette RAM read per entry through the single RAM
// port, then the distance pipeline drains.
// Reset clears the carried error and sets palette_size to 256; the palette
// needs no clearing pass. A held result stalls only the emit step, so the
// next item is taken and scanned while the previous result waits.
module dithered_nearest_palette_mapper_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        first_of_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  color_index_o
);
  import dnpm_pkg::*;

  logic [8:0] psize_q;
  ctl_t       ctl;
  stat_t      stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q <= PSIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_PALETTE_SIZE)) begin
      psize_q <= pwdata[8:0];
    end
  end

  assign prdata = (paddr[2] == REG_PALETTE_SIZE) ? {23'd0, psize_q} : 32'd0;

  dnpm_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctl_o (ctl)
  );

  dnpm_datapath #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .palette_size_i(psize_q),
    .in_valid_i    (in_valid_i),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .first_of_row_i(first_of_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .color_index_o (color_index_o)
  );

  assign in_ready_o = ctl.in_ready;

endmodule

### hw/rtl/dnpm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module dnpm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dnpm_seq.sv
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on dnpm_pkg for the step, condition and control word types.
module dnpm_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dnpm_pkg::stat_t stat_i,
  output dnpm_pkg::ctl_t  ctl_o
);
  import dnpm_pkg::*;

  step_e step_q, step_d;
  ctl_t  ctl;
  logic  taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    ctl = ucode(step_q);
    unique case (ctl.cond)
      C_NO_ITEM:   taken = !stat_i.item_valid;
      C_IS_LOAD:   taken = stat_i.is_load;
      C_SCAN_MORE: taken = stat_i.scan_more;
      C_PIPE_BUSY: taken = stat_i.pipe_busy;
      C_OUT_BUSY:  taken = stat_i.out_busy;
      default:     taken = 1'b0;
    endcase
    step_d = taken ? ctl.tgt_t : ctl.tgt_f;
  end

  assign ctl_o = ctl;

endmodule

### hw/rtl/dnpm_datapath.sv
// Datapath: input latch, error diffusion and snap, palette RAM, distance
// pipeline, best-match tracking, output register. Depends on dnpm_pkg, dnpm_ram.
module dnpm_datapath #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dnpm_pkg::ctl_t  ctl_i,
  output dnpm_pkg::stat_t stat_o,
  input  logic [8:0]      palette_size_i,
  input  logic            in_valid_i,
  input  logic            cmd_i,
  input  logic [7:0]      entry_index_i,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  input  logic            first_of_row_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      color_index_o
);
  import dnpm_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  function automatic logic [7:0] adjust(logic [7:0] v, logic signed [8:0] e);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + 10'(e >>> 1);
    if (s < 0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  function automatic logic [SQ_W-1:0] sqdiff(logic [7:0] a, logic [7:0] b);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  logic              accept;
  logic              cmd_q, first_q;
  logic [7:0]        idx_q, r_q, g_q, b_q;
  logic signed [8:0] er_q, eg_q, eb_q;
  logic signed [8:0] eff_r, eff_g, eff_b;
  logic [7:0]        pr_q, pg_q, pb_q, pr_d, pg_d, pb_d;
  logic [7:0]        sr_q, sg_q, sb_q;
  logic [AW-1:0]     last_q, last_d, addr_q, ram_addr;
  logic              ram_we;
  logic [23:0]       rdata;
  logic              v1_q, v2_q;
  logic [AW-1:0]     idx1_q, idx2_q, best_q;
  logic [23:0]       rgb2_q, best_rgb_q;
  logic [SQ_W-1:0]   sqr_q, sqg_q, sqb_q;
  logic [DIST_W-1:0] dist_sum, bestd_q;
  logic              out_valid_q, emit_fire, out_busy;
  logic [7:0]        color_q;

  assign accept = in_valid_i && ctl_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      idx_q   <= entry_index_i;
      r_q     <= red_i;
      g_q     <= green_i;
      b_q     <= blue_i;
      first_q <= first_of_row_i;
    end
  end

  assign eff_r = first_q ? 9'sd0 : er_q;
  assign eff_g = first_q ? 9'sd0 : eg_q;
  assign eff_b = first_q ? 9'sd0 : eb_q;
  assign pr_d  = adjust(r_q, eff_r);
  assign pg_d  = adjust(g_q, eff_g);
  assign pb_d  = adjust(b_q, eff_b);

  always_comb begin
    if (palette_size_i == 9'd0) begin
      last_d = '0;
    end else if (palette_size_i > 9'(PALETTE_DEPTH)) begin
      last_d = AW'(PALETTE_DEPTH - 1);
    end else begin
      last_d = AW'(palette_size_i - 9'd1);
    end
  end

  assign ram_we   = ctl_i.load && (cmd_q == CMD_LOAD) &&
                    ({1'b0, idx_q} < 9'(PALETTE_DEPTH));
  assign ram_addr = ram_we ? idx_q[AW-1:0] : addr_q;

  dnpm_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i({r_q, g_q, b_q}),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      pr_q <= pr_d;
      pg_q <= pg_d;
      pb_q <= pb_d;
      sr_q <= (pr_d & CELL_MASK) + CELL_HALF;
      sg_q <= (pg_d & CELL_MASK) + CELL_HALF;
      sb_q <= (pb_d & CELL_MASK) + CELL_HALF;
    end
    if (ctl_i.scan) begin
      addr_q <= addr_q + AW'(1);
    end else if (ctl_i.prep) begin
      addr_q <= '0;
    end
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    rgb2_q <= rdata;
    sqr_q  <= sqdiff(rdata[23:16], sr_q);
    sqg_q  <= sqdiff(rdata[15:8], sg_q);
    sqb_q  <= sqdiff(rdata[7:0], sb_q);
  end

  assign dist_sum = DIST_W'(sqr_q) + DIST_W'(sqg_q) + DIST_W'(sqb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      best_q  <= '0;
      last_q  <= '0;
      bestd_q <= '1;
    end else begin
      v1_q <= ctl_i.scan;
      v2_q <= v1_q;
      if (ctl_i.prep) begin
        best_q  <= '0;
        bestd_q <= '1;
        last_q  <= last_d;
      end else if (v2_q && (dist_sum < bestd_q)) begin
        best_q  <= idx2_q;
        bestd_q <= dist_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && (dist_sum < bestd_q)) begin
      best_rgb_q <= rgb2_q;
    end
  end

  assign out_busy  = out_valid_q && !out_ready_i;
  assign emit_fire = ctl_i.emit && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      er_q        <= '0;
      eg_q        <= '0;
      eb_q        <= '0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        er_q <= $signed({1'b0, pr_q}) - $signed({1'b0, best_rgb_q[23:16]});
        eg_q <= $signed({1'b0, pg_q}) - $signed({1'b0, best_rgb_q[15:8]});
        eb_q <= $signed({1'b0, pb_q}) - $signed({1'b0, best_rgb_q[7:0]});
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      color_q <= 8'(best_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_q;

  assign stat_o = '{item_valid: in_valid_i,
                    is_load:    (cmd_q == CMD_LOAD),
                    scan_more:  (addr_q != last_q),
                    pipe_busy:  (v1_q || v2_q),
                    out_busy:   out_busy};

  a_v1_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(ctl_i.scan))
    else $error("distance pipeline holds an entry that was never read");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> !(v1_q || v2_q))
    else $error("result emitted before the scan drained");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= last_q)
    else $error("best index beyond searched range");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (er_q != -9'sd256) && (eg_q != -9'sd256) && (eb_q != -9'sd256))
    else $error("carried error out of range");

endmodule
